@@ hdl/nmea_sentence_router_unit_macros.svh @@
// Assertion macros used by the sentence router unit.
`ifndef NMEA_SENTENCE_ROUTER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_ROUTER_UNIT_MACROS_SVH

// Checked property, switched off while reset is high.
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property that also holds through reset.
`define NSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/nsr_pkg.sv @@
// Types, codes and constant tables of the NMEA sentence router.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

  localparam int NUM_TYPES = 8;
  localparam int HEAD_LEN  = 6;
  localparam int CAP_W     = 9;
  localparam int LEN_W     = 9;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_COMMIT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef logic [2:0] stype_t;

  // Sentence heads in type order, '$' in the top byte.
  localparam logic [HEAD_LEN*8-1:0] TYPE_HEAD [NUM_TYPES] = '{
    "$GNGGA", "$GNGSA", "$GPGSV", "$BDGSV",
    "$GNRMC", "$GNVTG", "$GNGLL", "$GNZDA"
  };

  localparam logic [CAP_W-1:0] CAP_RESET [NUM_TYPES] = '{
    9'd72, 9'd72, 9'd210, 9'd210, 9'd72, 9'd40, 9'd64, 9'd64
  };

  function automatic logic [7:0] head_char(input stype_t t, input logic [2:0] k);
    logic [HEAD_LEN*8-1:0] h;
    h = TYPE_HEAD[t];
    return h[8*(HEAD_LEN-1-int'(k)) +: 8];
  endfunction

endpackage

`default_nettype wire

@@ hdl/nsr_req_if.sv @@
// Request channel: received bytes and stored-byte reads.
`timescale 1ns / 1ps
`default_nettype none

interface nsr_req_if import nsr_pkg::*; ();
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [7:0]  rx_byte;
  logic        buffer_start;
  stype_t      read_type;
  logic [7:0]  read_index;

  modport source (output valid, opcode, rx_byte, buffer_start, read_type, read_index,
                  input ready);
  modport sink   (input valid, opcode, rx_byte, buffer_start, read_type, read_index,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/nsr_rsp_if.sv @@
// Response channel: commit notices and read data.
`timescale 1ns / 1ps
`default_nettype none

interface nsr_rsp_if import nsr_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            result_kind;
  stype_t           sentence_type;
  logic [LEN_W-1:0] sentence_length;
  logic [7:0]       read_byte;

  modport source (output valid, result_kind, sentence_type, sentence_length, read_byte,
                  input ready);
  modport sink   (input valid, result_kind, sentence_type, sentence_length, read_byte,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/nmea_sentence_router_unit.sv @@
// NMEA sentence framer and router: line staging, header match, per-type sentence store.
//
// Received bytes are staged in a line memory from the latest '$'; the byte after a
// carriage return is staged and only checked for a line feed. A line feed that closes
// an armed sentence of more than MIN_SPAN+1 bytes that fits the line memory starts a
// commit: the six header bytes are read back one per cycle and matched against the
// eight types, and a match within that type's capacity is copied byte by byte into the
// sentence memory, which ends in a notice beat. A received byte is handled when accepted;
// a read passes accept, sentence memory read and output load; a commit passes line feed
// accept, header match, copy and output load, with the copy fed by the single read port
// of the line memory, and a line refused at the match goes back to idle. The output
// load waits while an earlier result is still held. Stored lengths live in flops, so
// sentence memory needs no clearing pass: bytes at or past a type's stored length read
// as zero. Capacities sit at byte address 4*i on the APB port. The output register
// lets a byte be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_router_unit import nsr_pkg::*; #(
  parameter int LINE_BYTES = 256,
  parameter int MIN_SPAN   = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  nsr_req_if.sink                req,
  nsr_rsp_if.source              rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  `include "nmea_sentence_router_unit_macros.svh"

  localparam int LW  = $clog2(LINE_BYTES);
  localparam int CW  = $clog2(LINE_BYTES + 2);
  localparam int SAW = $clog2(NUM_TYPES * LINE_BYTES);
  localparam logic [CW-1:0] OVER_MARK = CW'(LINE_BYTES + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_MATCH  = 5'b00100,
    S_COPY   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;

  logic [CAP_W-1:0] caps [NUM_TYPES];
  logic [CW-1:0]    stored_length [NUM_TYPES];
  logic             head_seen, after_cr;
  logic [CW-1:0]    staged_count;

  logic [7:0] line_mem [LINE_BYTES];
  logic [7:0] sent_mem [NUM_TYPES * LINE_BYTES];
  logic [7:0] line_rdata, sent_rdata;

  logic             line_we;
  logic [LW-1:0]    line_waddr, line_raddr;
  logic             sent_we;
  logic [SAW-1:0]   sent_waddr, sent_raddr;

  logic             head_seen_next, after_cr_next;
  logic [CW-1:0]    staged_count_next;
  logic             commit_go;

  logic [2:0]           mcnt;
  logic [NUM_TYPES-1:0] match_flags, flags_now, cap_ok;
  stype_t               first_type;
  logic                 first_hit;
  stype_t               cmt_type;

  logic [CW-1:0] cptr;
  logic [LW-1:0] wr_idx;
  logic          wr_pend, copy_issue;

  logic          rd_hit;
  stype_t        rd_type;
  logic [CW-1:0] rd_len;
  logic          rd_hit_q;

  kind_t            res_kind, out_kind;
  stype_t           res_type, out_type;
  logic [LEN_W-1:0] res_len, out_len;
  logic [7:0]       res_byte, out_byte;
  logic             out_valid;

  logic recv_acc, read_acc, cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = CFG_DW'(caps[paddr[4:2]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= CAP_RESET;
    end else if (cfg_wr) begin
      caps[paddr[4:2]] <= pwdata[CAP_W-1:0];
    end
  end

  assign req.ready = (state == S_IDLE);
  assign recv_acc  = req.valid && req.ready && (req.opcode == OP_RECV);
  assign read_acc  = req.valid && req.ready && (req.opcode == OP_READ);

  // Receive path: staging decision for one byte
  always_comb begin
    logic hs, ac;
    hs = req.buffer_start ? 1'b0 : head_seen;
    ac = req.buffer_start ? 1'b0 : after_cr;
    line_we           = 1'b0;
    line_waddr        = staged_count[LW-1:0];
    head_seen_next    = hs;
    after_cr_next     = ac;
    staged_count_next = staged_count;
    commit_go         = 1'b0;
    if (!ac && req.rx_byte == CHAR_DOLLAR) begin
      line_we           = 1'b1;
      line_waddr        = '0;
      staged_count_next = CW'(1);
      head_seen_next    = 1'b1;
    end else begin
      if (32'(staged_count) < 32'(LINE_BYTES)) begin
        line_we           = 1'b1;
        staged_count_next = staged_count + CW'(1);
      end else begin
        staged_count_next = OVER_MARK;
      end
      if (ac) begin
        after_cr_next = 1'b0;
        if (req.rx_byte == CHAR_LF && hs &&
            32'(staged_count_next) > 32'(MIN_SPAN + 1)) begin
          head_seen_next = 1'b0;
          commit_go      = (32'(staged_count_next) <= 32'(LINE_BYTES));
        end
      end else if (req.rx_byte == CHAR_CR) begin
        after_cr_next = 1'b1;
      end
    end
  end

  // Header match over the bytes read back one per cycle
  always_comb begin
    for (int t = 0; t < NUM_TYPES; t++) begin
      flags_now[t] = match_flags[t];
      if (mcnt != 3'd0 && line_rdata != head_char(stype_t'(t), 3'(mcnt - 3'd1))) begin
        flags_now[t] = 1'b0;
      end
      cap_ok[t] = (32'(caps[t]) >= 32'(staged_count));
    end
    first_hit  = 1'b0;
    first_type = '0;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if (flags_now[t]) begin
        first_hit  = 1'b1;
        first_type = stype_t'(t);
      end
    end
  end

  assign copy_issue = (state == S_COPY) && (cptr < staged_count);

  always_comb begin
    case (state)
      S_MATCH: line_raddr = LW'(mcnt);
      S_COPY:  line_raddr = cptr[LW-1:0];
      default: line_raddr = '0;
    endcase
  end

  // Line memory: one write port for staging, one read port for match and copy
  always_ff @(posedge clk) begin
    if (recv_acc && line_we) begin
      line_mem[line_waddr] <= req.rx_byte;
    end
    line_rdata <= line_mem[line_raddr];
  end

  assign rd_len     = stored_length[req.read_type];
  assign rd_hit     = 32'(req.read_index) < 32'(rd_len);
  assign sent_raddr = rd_hit ? SAW'(SAW'(req.read_type) * SAW'(LINE_BYTES) +
                                    SAW'(req.read_index)) : '0;
  assign sent_we    = wr_pend;
  assign sent_waddr = SAW'(SAW'(cmt_type) * SAW'(LINE_BYTES) + SAW'(wr_idx));

  // Sentence memory
  always_ff @(posedge clk) begin
    if (sent_we) begin
      sent_mem[sent_waddr] <= line_rdata;
    end
    sent_rdata <= sent_mem[sent_raddr];
  end

  // Sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_seen    <= 1'b0;
      after_cr     <= 1'b0;
      staged_count <= '0;
      wr_pend      <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        stored_length[t] <= '0;
      end
    end else begin
      wr_pend <= copy_issue;
      case (state)
        S_IDLE: begin
          if (recv_acc) begin
            head_seen    <= head_seen_next;
            after_cr     <= after_cr_next;
            staged_count <= staged_count_next;
            if (commit_go) begin
              state <= S_MATCH;
            end
          end else if (read_acc) begin
            state <= S_RDWAIT;
          end
        end
        S_RDWAIT: state <= S_DONE;
        S_MATCH: begin
          if (mcnt == 3'(HEAD_LEN)) begin
            state <= (first_hit && cap_ok[first_type]) ? S_COPY : S_IDLE;
          end
        end
        S_COPY: begin
          if (!copy_issue && !wr_pend) begin
            stored_length[cmt_type] <= staged_count;
            state                   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mcnt        <= '0;
        match_flags <= '1;
        rd_type     <= req.read_type;
        rd_hit_q    <= rd_hit;
        res_len     <= LEN_W'(rd_len);
      end
      S_RDWAIT: begin
        res_kind <= KIND_READ;
        res_type <= rd_type;
        res_byte <= rd_hit_q ? sent_rdata : 8'd0;
      end
      S_MATCH: begin
        mcnt        <= mcnt + 3'd1;
        match_flags <= flags_now;
        cmt_type    <= first_type;
        cptr        <= '0;
      end
      S_COPY: begin
        if (copy_issue) begin
          cptr <= cptr + CW'(1);
        end
        wr_idx   <= cptr[LW-1:0];
        res_kind <= KIND_COMMIT;
        res_type <= cmt_type;
        res_len  <= LEN_W'(staged_count);
        res_byte <= 8'd0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_kind <= res_kind;
      out_type <= res_type;
      out_len  <= res_len;
      out_byte <= res_byte;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_kind     = out_kind;
  assign rsp.sentence_type   = out_type;
  assign rsp.sentence_length = out_len;
  assign rsp.read_byte       = out_byte;

  `NSR_ASSERT_RST(a_reset_idle, rst |=> (!rsp.valid && state == S_IDLE),
    "reset left a result or a busy sequencer")
  `NSR_ASSERT(a_notice_shape,
    (rsp.valid && rsp.result_kind == KIND_COMMIT) |->
      (rsp.read_byte == 8'd0 && 32'(rsp.sentence_length) > 32'(MIN_SPAN + 1)),
    "commit notice with data byte or short length")
  `NSR_ASSERT(a_copy_in_range, sent_we |-> (32'(wr_idx) < 32'(staged_count)),
    "sentence write past the staged count")
  `NSR_ASSERT(a_head_cleared, (state == S_MATCH || state == S_COPY) |-> !head_seen,
    "head still armed during a commit")
  `NSR_ASSERT(a_busy_holds_line, (state != S_IDLE) |=> $stable(staged_count),
    "staged count moved while busy")

endmodule

`default_nettype wire
